// File: hdl/ubat_pkg.sv
// ----------------------------------------------------------------------------
// ubat_pkg
// Shared widths, codes, reset values and types of the baud sweep autotuner.
// ----------------------------------------------------------------------------
package ubat_pkg;

  localparam int NOM_W      = 12;
  localparam int THR_W      = 4;
  localparam int DIV_W      = 13;
  localparam int TX_W       = 14;
  localparam int CNT_W      = 8;
  localparam int POLL_W     = 8;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam int POLLS_DEFAULT = 10;

  localparam logic [BYTE_W-1:0] MATCH_BYTE = 8'h77;
  localparam logic [NOM_W-1:0]  NOM_RESET  = 12'd25;
  localparam logic [THR_W-1:0]  THR_RESET  = 4'd8;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 8'hFF;

  // item kind codes
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_POLL  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [NOM_W-1:0] nominal;
    logic [THR_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic              present;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic              running;
    logic [DIV_W-1:0]  cur_div;
    logic [POLL_W-1:0] poll_idx;
    logic [CNT_W-1:0]  match_cnt;
    logic [DIV_W-1:0]  low_mark;
    logic [DIV_W-1:0]  high_mark;
    logic              any_pass;
    logic [DIV_W-1:0]  rx_res;
    logic [TX_W-1:0]   tx_res;
  } sweep_state_t;

endpackage

// File: hdl/ubat_cfg_regs.sv
// ----------------------------------------------------------------------------
// ubat_cfg_regs
// Configuration register file: nominal divisor and quality threshold.
// ----------------------------------------------------------------------------
module ubat_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ubat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ubat_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ubat_pkg::cfg_t                      cfg
);

  ubat_pkg::cfg_t cfg_r;
  ubat_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ubat_pkg::CFG_NOMINAL:   cfg_nxt.nominal   = cfg_data[ubat_pkg::NOM_W-1:0];
        ubat_pkg::CFG_THRESHOLD: cfg_nxt.threshold = cfg_data[ubat_pkg::THR_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nominal   <= ubat_pkg::NOM_RESET;
      cfg_r.threshold <= ubat_pkg::THR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hdl/ubat_in_reg.sv
// ----------------------------------------------------------------------------
// ubat_in_reg
// Input register stage holding one accepted beat until the core takes it.
// ----------------------------------------------------------------------------
module ubat_in_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic                          in_byte_present,
  input  logic [ubat_pkg::BYTE_W-1:0]   in_received_byte,
  output logic                          item_valid,
  output ubat_pkg::item_t               item,
  input  logic                          item_take
);

  logic            valid_r;
  ubat_pkg::item_t item_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (item_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind    <= in_kind;
      item_r.present <= in_byte_present;
      item_r.rx_byte <= in_received_byte;
    end
  end

endmodule

// File: hdl/ubat_core.sv
// ----------------------------------------------------------------------------
// ubat_core
// Sweep state update for one beat and the registered result stage.
// ----------------------------------------------------------------------------
module ubat_core #(
  parameter int POLLS_PER_DIVISOR = ubat_pkg::POLLS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ubat_pkg::cfg_t                cfg,
  input  logic                          item_valid,
  input  ubat_pkg::item_t               item,
  output logic                          item_take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ubat_pkg::DIV_W-1:0]    out_trial_divisor,
  output logic                          out_busy_res,
  output logic                          out_finished,
  output logic                          out_found,
  output logic [ubat_pkg::DIV_W-1:0]    out_rx_divisor,
  output logic [ubat_pkg::TX_W-1:0]     out_tx_timing
);

  localparam logic [ubat_pkg::POLL_W-1:0] POLLS =
    ubat_pkg::POLL_W'(POLLS_PER_DIVISOR);

  ubat_pkg::sweep_state_t st_r;
  ubat_pkg::sweep_state_t st_nxt;

  logic                         out_valid_r;
  logic                         done_r;
  logic                         done;
  logic [ubat_pkg::DIV_W-1:0]   sweep_start;
  logic [ubat_pkg::DIV_W-1:0]   sweep_end;
  logic                         is_match;
  logic [ubat_pkg::CNT_W-1:0]   cnt_inc;
  logic [ubat_pkg::POLL_W-1:0]  poll_inc;
  logic [ubat_pkg::TX_W-1:0]    mark_diff;
  logic [ubat_pkg::TX_W-1:0]    mark_sum;

  assign item_take = item_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  assign sweep_start = ubat_pkg::DIV_W'(cfg.nominal >> 1);
  assign sweep_end   = ubat_pkg::DIV_W'(cfg.nominal) + ubat_pkg::DIV_W'(cfg.nominal >> 1);
  assign is_match    = item.present && (item.rx_byte == ubat_pkg::MATCH_BYTE);
  assign cnt_inc     = (st_r.match_cnt != ubat_pkg::CNT_MAX) ?
                       st_r.match_cnt + 1'b1 : st_r.match_cnt;
  assign poll_inc    = st_r.poll_idx + 1'b1;

  always_comb begin
    st_nxt    = st_r;
    done      = 1'b0;
    mark_diff = '0;
    mark_sum  = '0;
    if (item.kind == ubat_pkg::KIND_START) begin
      st_nxt.running   = 1'b1;
      st_nxt.cur_div   = sweep_start;
      st_nxt.poll_idx  = '0;
      st_nxt.match_cnt = '0;
      st_nxt.low_mark  = sweep_end;
      st_nxt.high_mark = sweep_start;
      st_nxt.any_pass  = 1'b0;
    end else if (st_r.running) begin
      if (is_match) begin
        st_nxt.match_cnt = cnt_inc;
        if (cnt_inc >= ubat_pkg::CNT_W'(cfg.threshold)) begin
          if (st_r.cur_div < st_r.low_mark) begin
            st_nxt.low_mark = st_r.cur_div;
            st_nxt.any_pass = 1'b1;
          end
          if (st_r.cur_div > st_r.high_mark) begin
            st_nxt.high_mark = st_r.cur_div;
            st_nxt.any_pass  = 1'b1;
          end
        end
      end
      st_nxt.poll_idx = poll_inc;
      if (poll_inc >= POLLS) begin
        st_nxt.poll_idx  = '0;
        st_nxt.match_cnt = '0;
        if (st_r.cur_div >= sweep_end) begin
          st_nxt.running = 1'b0;
          done           = 1'b1;
          if (st_nxt.any_pass) begin
            // midpoint and sum are taken from the markers after this beat's update
            mark_diff = ubat_pkg::TX_W'(st_nxt.high_mark) - ubat_pkg::TX_W'(st_nxt.low_mark);
            mark_sum  = ubat_pkg::TX_W'(st_nxt.high_mark) + ubat_pkg::TX_W'(st_nxt.low_mark);
            st_nxt.rx_res = st_nxt.low_mark + mark_diff[ubat_pkg::DIV_W:1];
            st_nxt.tx_res = mark_sum;
          end
        end else begin
          st_nxt.cur_div = st_r.cur_div + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        st_r <= st_nxt;
      end
      if (item_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result beat shows the state after its item
  always_ff @(posedge clk) begin
    if (item_take) begin
      out_trial_divisor <= st_nxt.cur_div;
      out_busy_res      <= st_nxt.running;
      done_r            <= done;
      out_found         <= st_nxt.any_pass;
      out_rx_divisor    <= st_nxt.rx_res;
      out_tx_timing     <= st_nxt.tx_res;
    end
  end

  assign out_finished = done_r;

endmodule

// File: hdl/uart_baud_sweep_autotune_unit.sv
// ----------------------------------------------------------------------------
// uart_baud_sweep_autotune_unit
// Sweeps a receive baud divisor and picks the center of the passing range.
// ----------------------------------------------------------------------------
// A start beat opens a sweep from nominal/2 to nominal + nominal/2; each poll
// beat reports one receiver sample, and every divisor gets POLLS_PER_DIVISOR
// polls in which 'w' bytes are counted against the quality threshold. Every
// input beat yields exactly one result beat carrying the state after it. The
// block takes one beat per clock unless out_ready holds the result back: the
// whole state update is combinational compare and add logic between the input
// register and the result register, and the input register takes one more
// beat while an old result waits.
module uart_baud_sweep_autotune_unit #(
  parameter int POLLS_PER_DIVISOR = ubat_pkg::POLLS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ubat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ubat_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic                              in_byte_present,
  input  logic [ubat_pkg::BYTE_W-1:0]       in_received_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ubat_pkg::DIV_W-1:0]        out_trial_divisor,
  output logic                              out_busy_res,
  output logic                              out_finished,
  output logic                              out_found,
  output logic [ubat_pkg::DIV_W-1:0]        out_rx_divisor,
  output logic [ubat_pkg::TX_W-1:0]         out_tx_timing
);

  ubat_pkg::cfg_t  cfg;
  ubat_pkg::item_t item;
  logic            item_valid;
  logic            item_take;

  ubat_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ubat_in_reg u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_byte_present  (in_byte_present),
    .in_received_byte (in_received_byte),
    .item_valid       (item_valid),
    .item             (item),
    .item_take        (item_take)
  );

  ubat_core #(
    .POLLS_PER_DIVISOR (POLLS_PER_DIVISOR)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .item_valid        (item_valid),
    .item              (item),
    .item_take         (item_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trial_divisor (out_trial_divisor),
    .out_busy_res      (out_busy_res),
    .out_finished      (out_finished),
    .out_found         (out_found),
    .out_rx_divisor    (out_rx_divisor),
    .out_tx_timing     (out_tx_timing)
  );

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the baud sweep autotuner.
// ----------------------------------------------------------------------------
// Drives start and poll beats through the valid/ready input channel. Each
// accepted beat is run through a cycle-free model of the sweep, and the
// predicted report is queued. Every result beat is checked field by field
// against the oldest queued report. Registers change only while the pipe is
// empty. Both sides idle at random, and the receiver stalls once long enough
// to back up the input. The stimulus is a directed opener, restart and
// mid-sweep reconfiguration cases, then mostly well-formed sweeps with noise.
module tb_top;
  import ubat_pkg::*;

  localparam int POLLS       = POLLS_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [DIV_W-1:0] trial;
    logic             busy;
    logic             finished;
    logic             found;
    logic [DIV_W-1:0] rx_div;
    logic [TX_W-1:0]  tx_val;
  } report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = KIND_POLL;
  logic                  in_byte_present = 1'b0;
  logic [BYTE_W-1:0]     in_received_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DIV_W-1:0]      out_trial_divisor;
  logic                  out_busy_res;
  logic                  out_finished;
  logic                  out_found;
  logic [DIV_W-1:0]      out_rx_divisor;
  logic [TX_W-1:0]       out_tx_timing;

  // model of the sweep and its registers
  sweep_state_t tune_st;
  cfg_t         sweep_cfg;

  report_t     expected_reports[$];
  int unsigned live_items = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold_cycles = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  uart_baud_sweep_autotune_unit #(.POLLS_PER_DIVISOR(POLLS)) dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // sweep model: state after one accepted beat
  // ---------------------------------------------------------------------------
  function automatic report_t advance_sweep(item_t it);
    report_t          rep;
    logic [DIV_W-1:0] first_div;
    logic [DIV_W-1:0] last_div;
    int unsigned      lo;
    int unsigned      hi;
    rep.finished = 1'b0;
    first_div = DIV_W'(sweep_cfg.nominal >> 1);
    last_div  = DIV_W'(sweep_cfg.nominal) + DIV_W'(sweep_cfg.nominal >> 1);
    if (it.kind == KIND_START) begin
      live_items++;
      tune_st.running   = 1'b1;
      tune_st.cur_div   = first_div;
      tune_st.poll_idx  = '0;
      tune_st.match_cnt = '0;
      tune_st.low_mark  = last_div;
      tune_st.high_mark = first_div;
      tune_st.any_pass  = 1'b0;
    end else if (tune_st.running) begin
      live_items++;
      if (it.present && it.rx_byte == MATCH_BYTE) begin
        if (tune_st.match_cnt != CNT_MAX) tune_st.match_cnt++;
        if (tune_st.match_cnt >= CNT_W'(sweep_cfg.threshold)) begin
          if (tune_st.cur_div < tune_st.low_mark) begin
            tune_st.low_mark = tune_st.cur_div;
            tune_st.any_pass = 1'b1;
          end
          if (tune_st.cur_div > tune_st.high_mark) begin
            tune_st.high_mark = tune_st.cur_div;
            tune_st.any_pass  = 1'b1;
          end
        end
      end
      tune_st.poll_idx++;
      if (tune_st.poll_idx >= POLL_W'(POLLS)) begin
        tune_st.poll_idx  = '0;
        tune_st.match_cnt = '0;
        if (tune_st.cur_div >= last_div) begin
          tune_st.running = 1'b0;
          rep.finished    = 1'b1;
          if (tune_st.any_pass) begin
            lo = tune_st.low_mark;
            hi = tune_st.high_mark;
            tune_st.rx_res = DIV_W'(lo + ((hi - lo) >> 1));
            tune_st.tx_res = TX_W'(lo + hi);
          end
        end else begin
          tune_st.cur_div = tune_st.cur_div + 1'b1;
        end
      end
    end
    rep.trial  = tune_st.cur_div;
    rep.busy   = tune_st.running;
    rep.found  = tune_st.any_pass;
    rep.rx_div = tune_st.rx_res;
    rep.tx_val = tune_st.tx_res;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_item(logic kind, logic present, logic [BYTE_W-1:0] rx_byte);
    item_t       it;
    int unsigned gap;
    it.kind    = kind;
    it.present = present;
    it.rx_byte = rx_byte;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_byte_present  <= present;
    in_received_byte <= rx_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_reports.push_back(advance_sweep(it));
  endtask

  // drop valid and let every outstanding result come back
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_NOMINAL) sweep_cfg.nominal = data;
    else sweep_cfg.threshold = data[THR_W-1:0];
  endtask

  // polls until the sweep ends; divisors near center mostly see 'w'
  task automatic sweep_polls(int unsigned center, int unsigned reach);
    int unsigned cd;
    int unsigned pick;
    while (tune_st.running) begin
      cd   = tune_st.cur_div;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 299) == 0)
        send_item(KIND_START, 1'($urandom), 8'($urandom));
      else if (cd + reach >= center && cd <= center + reach && pick < 85)
        send_item(KIND_POLL, 1'b1, MATCH_BYTE);
      else if (pick < 90)
        send_item(KIND_POLL, 1'b0, (pick < 87) ? MATCH_BYTE : 8'($urandom));
      else if (pick < 94)
        send_item(KIND_POLL, 1'b1, MATCH_BYTE);
      else
        send_item(KIND_POLL, 1'b1, 8'($urandom));
    end
  endtask

  task automatic run_sweep(int unsigned center, int unsigned reach);
    send_item(KIND_START, 1'($urandom), 8'($urandom));
    sweep_polls(center, reach);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_idle_polls();
    send_item(KIND_POLL, 1'b1, MATCH_BYTE);
    send_item(KIND_POLL, 1'b0, 8'h00);
    send_item(KIND_POLL, 1'b1, 8'hFF);
  endtask

  // nominal 1 sweeps divisors 0 and 1; threshold zero passes on a single 'w'
  task automatic test_short_sweep();
    int i;
    write_reg(CFG_THRESHOLD, 12'h000);
    write_reg(CFG_NOMINAL, 12'd1);
    send_item(KIND_START, 1'b1, MATCH_BYTE);
    for (i = 0; i < POLLS; i++) begin
      case (i)
        0: send_item(KIND_POLL, 1'b1, 8'h00);
        1: send_item(KIND_POLL, 1'b0, MATCH_BYTE);
        2: send_item(KIND_POLL, 1'b1, MATCH_BYTE);
        3: send_item(KIND_POLL, 1'b1, 8'hFF);
        default: send_item(KIND_POLL, 1'b1, 8'h76);
      endcase
    end
    for (i = 0; i < POLLS; i++) begin
      if (i == POLLS - 1) send_item(KIND_POLL, 1'b1, MATCH_BYTE);
      else send_item(KIND_POLL, 1'b1, 8'h57);
    end
    send_item(KIND_POLL, 1'b1, MATCH_BYTE);
  endtask

  // restart while running, and nominal rewritten in the middle of a sweep
  task automatic test_restart_and_reconfig();
    int i;
    write_reg(CFG_THRESHOLD, 12'hF0F);
    write_reg(CFG_NOMINAL, 12'd4095);
    send_item(KIND_START, 1'b0, 8'h00);
    for (i = 0; i < 25; i++) send_item(KIND_POLL, 1'b1, MATCH_BYTE);
    send_item(KIND_START, 1'b1, 8'hFF);
    for (i = 0; i < 12; i++) send_item(KIND_POLL, 1'($urandom), 8'($urandom));
    // end of sweep drops far below the divisor in test
    write_reg(CFG_NOMINAL, 12'd3);
    sweep_polls(0, 0);
    write_reg(CFG_THRESHOLD, 12'h001);
    write_reg(CFG_NOMINAL, 12'd2);
    send_item(KIND_START, 1'b0, MATCH_BYTE);
    for (i = 0; i < 15; i++) send_item(KIND_POLL, 1'b1, MATCH_BYTE);
    // end of sweep moves out past the divisor in test
    write_reg(CFG_NOMINAL, 12'd6);
    sweep_polls(5, 2);
    write_reg(CFG_NOMINAL, 12'd0);
    run_sweep(0, 0);
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    write_reg(CFG_THRESHOLD, 12'd3);
    write_reg(CFG_NOMINAL, 12'd3);
    rx_hold_cycles = 250;
    run_sweep(2, 1);
    settle();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_sweeps(int unsigned n_items);
    int unsigned target;
    int unsigned nom;
    int unsigned thr;
    int unsigned first;
    int unsigned last;
    int unsigned r;
    int unsigned n;
    target = live_items + n_items;
    while (live_items < target) begin
      tx_idle_on = $urandom_range(0, 2) != 0;
      rx_idle_on = $urandom_range(0, 2) != 0;
      r = $urandom_range(0, 19);
      if (r == 0) nom = 0;
      else if (r == 1) nom = $urandom_range(9, 24);
      else nom = $urandom_range(1, 8);
      r = $urandom_range(0, 9);
      if (r == 0) thr = 0;
      else if (r == 1) thr = $urandom_range(11, 15);
      else if (r == 2) thr = 10;
      else if (r == 3) thr = 1;
      else thr = $urandom_range(1, 10);
      if ($urandom_range(0, 2) != 0) write_reg(CFG_NOMINAL, CFG_DATA_W'(nom));
      if ($urandom_range(0, 2) != 0)
        write_reg(CFG_THRESHOLD, {8'($urandom), 4'(thr)});
      first = sweep_cfg.nominal >> 1;
      last  = sweep_cfg.nominal + (sweep_cfg.nominal >> 1);
      if ($urandom_range(0, 3) == 0) begin
        // loose beats, possibly leaving a sweep half done
        n = $urandom_range(3, 12);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) send_item(KIND_START, 1'($urandom), 8'($urandom));
          else send_item(KIND_POLL, 1'($urandom), 8'($urandom));
        end
      end else begin
        run_sweep($urandom_range(first, last), $urandom_range(0, 2));
      end
    end
    settle();
  endtask

  task automatic test_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_reg(CFG_THRESHOLD, 12'd10);
    write_reg(CFG_NOMINAL, 12'd5);
    run_sweep(4, 1);
    write_reg(CFG_THRESHOLD, 12'd2);
    run_sweep(6, 2);
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, trial_divisor %0d",
                 $time, out_trial_divisor);
      end else begin
        want = expected_reports.pop_front();
        check_field("trial_divisor", want.trial, out_trial_divisor);
        check_field("busy_res", want.busy, out_busy_res);
        check_field("finished", want.finished, out_finished);
        check_field("found", want.found, out_found);
        check_field("rx_divisor", want.rx_div, out_rx_divisor);
        check_field("tx_timing", want.tx_val, out_tx_timing);
      end
    end
  end

  initial begin
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned wait_cnt;
    tune_st           = '0;
    sweep_cfg.nominal   = NOM_RESET;
    sweep_cfg.threshold = THR_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_polls();
    test_short_sweep();
    test_restart_and_reconfig();
    test_backpressure();
    test_random_sweeps(750);
    test_no_idle();

    in_valid <= 1'b0;
    wait_cnt = 0;
    while (expected_reports.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (expected_reports.size() != 0) begin
      mismatches++;
      $display("%0t: %0d result beats never arrived", $time, expected_reports.size());
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/ubat_pkg.sv
hdl/ubat_cfg_regs.sv
hdl/ubat_in_reg.sv
hdl/ubat_core.sv
hdl/uart_baud_sweep_autotune_unit.sv
verif/tb_top.sv
